// File: src/pcat_pkg.sv
// shared types and constants for the page chain allocation table
// request and response payloads, operation and state codes, link markers
// no dependencies
package pcat_pkg;

   localparam int PAGE_W  = 7;
   localparam int ENTRY_W = 16;

   localparam int DEFAULT_TABLE_ENTRIES   = 128;
   localparam int DEFAULT_FIRST_DATA_PAGE = 5;

   localparam logic [ENTRY_W-1:0] MARK_END  = 16'h0001;
   localparam logic [ENTRY_W-1:0] MARK_FREE = 16'h0003;

   typedef enum logic [1:0] {
      MODE_LOAD   = 2'd0,
      MODE_READ   = 2'd1,
      MODE_FREE   = 2'd2,
      MODE_FORMAT = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_WALK,
      ST_FORMAT
   } state_type;

   typedef struct packed {
      mode_type             mode;
      logic [PAGE_W-1:0]    page;
      logic [ENTRY_W-1:0]   value;
   } req_type;

   typedef struct packed {
      logic [ENTRY_W-1:0]   entry_value;
      logic                 status;
   } rsp_type;

   // memory port strobes from the sequencer
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

// File: src/pcat_ram.sv
// link table storage: one write port, one read port, registered read data
// read during write to the same entry returns the old contents
// depends on pcat_pkg
module pcat_ram #(
   parameter int TABLE_ENTRIES = pcat_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  logic                            clock,
   input  pcat_pkg::mem_ctl_type           mem_ctl,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
   input  logic [pcat_pkg::ENTRY_W-1:0]    wr_data,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
   output logic [pcat_pkg::ENTRY_W-1:0]    rd_data
);

   logic [pcat_pkg::ENTRY_W-1:0] table_mem [TABLE_ENTRIES];
   logic [pcat_pkg::ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/pcat_ctrl.sv
// sequencer for load, read, chain free and format over the link table memory
// drives the memory ports, forwards a free marker on self-linked entries
// depends on pcat_pkg
module pcat_ctrl #(
   parameter int TABLE_ENTRIES   = pcat_pkg::DEFAULT_TABLE_ENTRIES,
   parameter int FIRST_DATA_PAGE = pcat_pkg::DEFAULT_FIRST_DATA_PAGE
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  pcat_pkg::req_type                req_data,
   output logic                             rsp_valid,
   output pcat_pkg::rsp_type                rsp_data,
   output pcat_pkg::mem_ctl_type            mem_ctl,
   output logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
   output logic [pcat_pkg::ENTRY_W-1:0]     wr_data,
   output logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
   input  logic [pcat_pkg::ENTRY_W-1:0]     rd_data
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int SW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [pcat_pkg::ENTRY_W-1:0] TE_LIM  = pcat_pkg::ENTRY_W'(TABLE_ENTRIES);
   localparam logic [pcat_pkg::ENTRY_W-1:0] FDP_LIM = pcat_pkg::ENTRY_W'(FIRST_DATA_PAGE);

   pcat_pkg::state_type state_ff, state_in;
   logic [IW-1:0]       cur_ff, cur_in;
   logic [SW-1:0]       steps_ff, steps_in;
   logic                fwd_ff, fwd_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pcat_pkg::rsp_type   rsp_ff, rsp_in;

   logic [pcat_pkg::ENTRY_W-1:0] page_ext;
   logic [pcat_pkg::ENTRY_W-1:0] cur_ext;
   logic [pcat_pkg::ENTRY_W-1:0] nxt;
   logic [IW-1:0]                nxt_idx;
   logic                         page_ok;
   logic                         start_ok;
   logic                         walk_stop;
   logic                         fmt_last;
   logic                         accept;

   assign accept   = start && (state_ff == pcat_pkg::ST_IDLE);
   assign page_ext = pcat_pkg::ENTRY_W'(req_data.page);
   assign cur_ext  = pcat_pkg::ENTRY_W'(cur_ff);
   assign page_ok  = page_ext < TE_LIM;
   assign start_ok = page_ok && (page_ext >= FDP_LIM);

   // entry just written free and read back in the same cycle
   assign nxt       = fwd_ff ? pcat_pkg::MARK_FREE : rd_data;
   assign nxt_idx   = nxt[IW-1:0];
   assign walk_stop = (nxt == pcat_pkg::MARK_END) || (nxt == pcat_pkg::MARK_FREE)
                   || (nxt < FDP_LIM) || (nxt >= TE_LIM)
                   || (steps_ff == SW'(TABLE_ENTRIES - 1));
   assign fmt_last  = cur_ff == IW'(TABLE_ENTRIES - 1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pcat_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_data.mode)
                  pcat_pkg::MODE_LOAD:   state_in = pcat_pkg::ST_IDLE;
                  pcat_pkg::MODE_READ:   state_in = page_ok ? pcat_pkg::ST_READ_WAIT
                                                            : pcat_pkg::ST_IDLE;
                  pcat_pkg::MODE_FREE:   state_in = start_ok ? pcat_pkg::ST_WALK
                                                             : pcat_pkg::ST_IDLE;
                  pcat_pkg::MODE_FORMAT: state_in = pcat_pkg::ST_FORMAT;
               endcase
            end
         end
         pcat_pkg::ST_READ_WAIT: state_in = pcat_pkg::ST_IDLE;
         pcat_pkg::ST_WALK: begin
            if (walk_stop) begin
               state_in = pcat_pkg::ST_IDLE;
            end
         end
         pcat_pkg::ST_FORMAT: begin
            if (fmt_last) begin
               state_in = pcat_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      mem_ctl      = '0;
      wr_addr      = cur_ff;
      wr_data      = pcat_pkg::MARK_FREE;
      rd_addr      = cur_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      fwd_in       = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         pcat_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_data.mode)
                  pcat_pkg::MODE_LOAD: begin
                     mem_ctl.wr_en = page_ok;
                     wr_addr       = IW'(req_data.page);
                     wr_data       = req_data.value;
                     rsp_valid_in  = 1'b1;
                     rsp_in        = '0;
                  end
                  pcat_pkg::MODE_READ: begin
                     mem_ctl.rd_en = page_ok;
                     rd_addr       = IW'(req_data.page);
                     rsp_valid_in  = !page_ok;
                     rsp_in        = '0;
                  end
                  pcat_pkg::MODE_FREE: begin
                     mem_ctl.rd_en = start_ok;
                     rd_addr       = IW'(req_data.page);
                     cur_in        = IW'(req_data.page);
                     steps_in      = '0;
                     rsp_valid_in  = !start_ok;
                     rsp_in        = '0;
                     rsp_in.status = !start_ok;
                  end
                  pcat_pkg::MODE_FORMAT: begin
                     cur_in = '0;
                  end
               endcase
            end
         end
         pcat_pkg::ST_READ_WAIT: begin
            rsp_valid_in       = 1'b1;
            rsp_in.entry_value = rd_data;
            rsp_in.status      = 1'b0;
         end
         pcat_pkg::ST_WALK: begin
            mem_ctl.wr_en = 1'b1;
            steps_in      = steps_ff + SW'(1);
            if (walk_stop) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
            end else begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = nxt_idx;
               cur_in        = nxt_idx;
               fwd_in        = nxt_idx == cur_ff;
            end
         end
         pcat_pkg::ST_FORMAT: begin
            mem_ctl.wr_en = 1'b1;
            wr_data       = (cur_ext < FDP_LIM) ? pcat_pkg::MARK_END : pcat_pkg::MARK_FREE;
            cur_in        = cur_ff + IW'(1);
            if (fmt_last) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcat_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_ff       <= fwd_in;
      end
      cur_ff   <= cur_in;
      steps_ff <= steps_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = state_ff != pcat_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: src/page_chain_allocation_table_unit.sv
// channel   ports                     handshake
// request   start, busy, req_data     taken when start is high and busy is low
// response  rsp_valid, rsp_data       one-cycle strobe, cannot be held off
//
// load and a free with a bad start page answer in the cycle after the request,
// a read after its registered memory read and the READ_WAIT state; a chain
// free frees one page per WALK step until the walk stops, and a format writes
// every entry in turn in FORMAT. busy is high while a read, chain free or format runs.
// reset returns the sequencer to idle; table contents are undefined until a
// load or format writes them.
//
// top level: sequencer plus link table memory, depends on pcat_pkg
module page_chain_allocation_table_unit #(
   parameter int TABLE_ENTRIES   = pcat_pkg::DEFAULT_TABLE_ENTRIES,
   parameter int FIRST_DATA_PAGE = pcat_pkg::DEFAULT_FIRST_DATA_PAGE
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pcat_pkg::req_type req_data,
   output logic              rsp_valid,
   output pcat_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(TABLE_ENTRIES);

   pcat_pkg::mem_ctl_type        mem_ctl;
   logic [IW-1:0]                wr_addr;
   logic [pcat_pkg::ENTRY_W-1:0] wr_data;
   logic [IW-1:0]                rd_addr;
   logic [pcat_pkg::ENTRY_W-1:0] rd_data;

   pcat_ctrl #(
      .TABLE_ENTRIES   (TABLE_ENTRIES),
      .FIRST_DATA_PAGE (FIRST_DATA_PAGE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .mem_ctl   (mem_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   pcat_ram #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

`ifndef SYNTHESIS
   // a response never shows while an operation is still running
   a_no_rsp_when_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("response strobe while busy");

   // load answers next cycle with an all-zero response
   a_load_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.mode == pcat_pkg::MODE_LOAD)
      |=> (rsp_valid && rsp_data == '0))
      else $error("load response missing or nonzero");

   // free from a system page is rejected at once with status set
   a_bad_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.mode == pcat_pkg::MODE_FREE
       && int'(req_data.page) < FIRST_DATA_PAGE)
      |=> (rsp_valid && rsp_data.status && !busy))
      else $error("bad start page not rejected");
`endif

endmodule

// File: tb/pcat_checker.sv
// response checker for the page chain allocation table unit
// keeps its own copy of the link table, predicts each response and compares
// depends on pcat_pkg
module pcat_checker #(
   parameter int TABLE_ENTRIES   = pcat_pkg::DEFAULT_TABLE_ENTRIES,
   parameter int FIRST_DATA_PAGE = pcat_pkg::DEFAULT_FIRST_DATA_PAGE
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  pcat_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  pcat_pkg::rsp_type rsp_data,
   output int                err_count,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [pcat_pkg::ENTRY_W-1:0] link_shadow [TABLE_ENTRIES];
   pcat_pkg::rsp_type            expected_rsp_q [$];

   assign pending = expected_rsp_q.size();

   function automatic bit in_data_area(input int p);
      return p >= FIRST_DATA_PAGE && p < TABLE_ENTRIES;
   endfunction

   // applies one request to the shadow table and returns the response it owes
   function automatic pcat_pkg::rsp_type predict_response(input pcat_pkg::req_type r);
      pcat_pkg::rsp_type            rsp;
      int                           cur;
      int                           step;
      bit                           stop;
      logic [pcat_pkg::ENTRY_W-1:0] nxt;
      rsp = '0;
      case (r.mode)
         pcat_pkg::MODE_LOAD: begin
            if (int'(r.page) < TABLE_ENTRIES) link_shadow[r.page] = r.value;
         end
         pcat_pkg::MODE_READ: begin
            if (int'(r.page) < TABLE_ENTRIES) rsp.entry_value = link_shadow[r.page];
         end
         pcat_pkg::MODE_FREE: begin
            if (!in_data_area(int'(r.page))) begin
               rsp.status = 1'b1;
            end else begin
               cur  = int'(r.page);
               stop = 1'b0;
               for (step = 0; step < TABLE_ENTRIES && !stop; step++) begin
                  nxt = link_shadow[cur];
                  link_shadow[cur] = pcat_pkg::MARK_FREE;
                  // walk ends on a marker or a link that leaves the data area
                  if (nxt == pcat_pkg::MARK_END || nxt == pcat_pkg::MARK_FREE
                      || !in_data_area(int'(nxt)))
                     stop = 1'b1;
                  else
                     cur = int'(nxt);
               end
            end
         end
         default: begin
            for (cur = 0; cur < TABLE_ENTRIES; cur++)
               link_shadow[cur] = (cur < FIRST_DATA_PAGE) ? pcat_pkg::MARK_END
                                                          : pcat_pkg::MARK_FREE;
         end
      endcase
      return rsp;
   endfunction

   always @(posedge clock) begin
      pcat_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t pcat_checker: response entry_value %04h status %0d, none expected",
                        $time, rsp_data.entry_value, rsp_data.status);
               err_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.entry_value !== want.entry_value) begin
                  $display("%0t pcat_checker: entry_value expected %04h actual %04h",
                           $time, want.entry_value, rsp_data.entry_value);
                  err_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $display("%0t pcat_checker: status expected %0d actual %0d",
                           $time, want.status, rsp_data.status);
                  err_count++;
               end
            end
         end
         // a request accepted at this edge is answered at a later one
         if (start && !busy)
            expected_rsp_q.push_back(predict_response(req_data));
      end
   end

endmodule

// File: tb/tb_top.sv
// top of the page chain allocation table testbench: clock, reset and requests
// directed requests first, then random chains and noise; pcat_checker judges
// depends on pcat_pkg, page_chain_allocation_table_unit and pcat_checker
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_ENTRIES   = pcat_pkg::DEFAULT_TABLE_ENTRIES;
   localparam int FIRST_DATA_PAGE = pcat_pkg::DEFAULT_FIRST_DATA_PAGE;
   localparam int NUM_DATA_PAGES  = TABLE_ENTRIES - FIRST_DATA_PAGE;
   localparam int TOTAL_REQUESTS  = 1200;
   localparam int EW              = pcat_pkg::ENTRY_W;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   pcat_pkg::req_type req_data = '0;
   logic              rsp_valid;
   pcat_pkg::rsp_type rsp_data;
   int                err_count;
   int                pending;

   int n_sent;
   int mode_cnt [4];
   int burst_left;
   int chains_freed;
   int longest_chain;
   int data_pages [NUM_DATA_PAGES];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   page_chain_allocation_table_unit #(
      .TABLE_ENTRIES  (TABLE_ENTRIES),
      .FIRST_DATA_PAGE(FIRST_DATA_PAGE)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   pcat_checker #(
      .TABLE_ENTRIES  (TABLE_ENTRIES),
      .FIRST_DATA_PAGE(FIRST_DATA_PAGE)
   ) i_checker (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .err_count(err_count),
      .pending  (pending)
   );

   // sends one request; start stays high across a burst, drops for a gap
   task automatic issue(input pcat_pkg::mode_type m, input int pg, input logic [EW-1:0] v);
      pcat_pkg::req_type r;
      int                gap;
      r.mode  = m;
      r.page  = pg[pcat_pkg::PAGE_W-1:0];
      r.value = v;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      n_sent++;
      mode_cnt[int'(m)]++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic shuffle_data_pages();
      int k;
      int j;
      int t;
      for (k = 0; k < NUM_DATA_PAGES; k++) data_pages[k] = FIRST_DATA_PAGE + k;
      for (k = NUM_DATA_PAGES - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         t = data_pages[k];
         data_pages[k] = data_pages[j];
         data_pages[j] = t;
      end
   endtask

   // links distinct data pages into a chain, ends it some way, frees it, reads back
   task automatic chain_and_free();
      int            len;
      int            k;
      int            kind;
      logic [EW-1:0] tail;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, NUM_DATA_PAGES)
                                         : $urandom_range(1, 8);
      shuffle_data_pages();
      for (k = 0; k < len - 1; k++)
         issue(pcat_pkg::MODE_LOAD, data_pages[k], EW'(data_pages[k + 1]));
      kind = $urandom_range(0, 9);
      if (kind < 6)
         tail = pcat_pkg::MARK_END;
      else if (kind == 6)
         tail = pcat_pkg::MARK_FREE;
      else if (kind == 7)
         tail = EW'($urandom_range(0, FIRST_DATA_PAGE - 1));
      else if (kind == 8)
         tail = EW'(data_pages[$urandom_range(0, len - 1)]);   // loops back
      else
         tail = EW'($urandom_range(TABLE_ENTRIES, 65535));
      issue(pcat_pkg::MODE_LOAD, data_pages[len - 1], tail);
      if ($urandom_range(0, 3) == 0)
         issue(pcat_pkg::MODE_READ, data_pages[$urandom_range(0, len - 1)], EW'($urandom));
      issue(pcat_pkg::MODE_FREE, data_pages[0], EW'($urandom));
      repeat ($urandom_range(1, 3))
         issue(pcat_pkg::MODE_READ, data_pages[$urandom_range(0, len - 1)], EW'($urandom));
      chains_freed++;
      if (len > longest_chain) longest_chain = len;
   endtask

   initial begin
      #20_000_000;
      $display("tb_top: timeout with %0d responses outstanding", pending);
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      int pick;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: every entry gets written by the format before any read
      issue(pcat_pkg::MODE_FORMAT, 0, 16'h0000);
      issue(pcat_pkg::MODE_READ, 0, 16'hFFFF);
      issue(pcat_pkg::MODE_READ, FIRST_DATA_PAGE, 16'h0000);
      issue(pcat_pkg::MODE_READ, TABLE_ENTRIES - 1, 16'h0000);
      issue(pcat_pkg::MODE_LOAD, TABLE_ENTRIES - 1, 16'hFFFF);
      issue(pcat_pkg::MODE_READ, TABLE_ENTRIES - 1, 16'h0000);
      // free starting on a system page is refused
      issue(pcat_pkg::MODE_FREE, 0, 16'h0000);
      issue(pcat_pkg::MODE_FREE, FIRST_DATA_PAGE - 1, 16'h0000);
      // link far outside the table stops the walk after one page
      issue(pcat_pkg::MODE_FREE, TABLE_ENTRIES - 1, 16'h0000);
      issue(pcat_pkg::MODE_READ, TABLE_ENTRIES - 1, 16'h0000);
      issue(pcat_pkg::MODE_LOAD, 5, 16'd10);
      issue(pcat_pkg::MODE_LOAD, 10, 16'd127);
      issue(pcat_pkg::MODE_LOAD, 127, pcat_pkg::MARK_END);
      issue(pcat_pkg::MODE_FREE, 5, 16'h0000);
      issue(pcat_pkg::MODE_READ, 10, 16'h0000);
      // chain that points back on itself
      issue(pcat_pkg::MODE_LOAD, 6, 16'd7);
      issue(pcat_pkg::MODE_LOAD, 7, 16'd6);
      issue(pcat_pkg::MODE_FREE, 6, 16'h0000);
      issue(pcat_pkg::MODE_READ, 6, 16'h0000);
      // link into the system area ends the walk
      issue(pcat_pkg::MODE_LOAD, 8, 16'd2);
      issue(pcat_pkg::MODE_FREE, 8, 16'h0000);
      issue(pcat_pkg::MODE_READ, 2, 16'h0000);
      // free on a page already free
      issue(pcat_pkg::MODE_FREE, 9, 16'h0000);
      issue(pcat_pkg::MODE_LOAD, 0, 16'h0000);
      issue(pcat_pkg::MODE_READ, 0, 16'h0000);

      while (n_sent < TOTAL_REQUESTS) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)
            chain_and_free();
         else if (pick < 75)
            issue(pcat_pkg::MODE_READ, $urandom_range(0, TABLE_ENTRIES - 1), EW'($urandom));
         else if (pick < 88)
            issue(pcat_pkg::MODE_LOAD, $urandom_range(0, TABLE_ENTRIES - 1), EW'($urandom));
         else if (pick < 97)
            issue(pcat_pkg::MODE_FREE, $urandom_range(0, TABLE_ENTRIES - 1), EW'($urandom));
         else
            issue(pcat_pkg::MODE_FORMAT, $urandom_range(0, TABLE_ENTRIES - 1),
                  EW'($urandom));
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (TABLE_ENTRIES + 20) @(posedge clock);

      $display("tb_top: %0d requests: %0d load, %0d read, %0d free, %0d format",
               n_sent, mode_cnt[pcat_pkg::MODE_LOAD], mode_cnt[pcat_pkg::MODE_READ],
               mode_cnt[pcat_pkg::MODE_FREE], mode_cnt[pcat_pkg::MODE_FORMAT]);
      $display("tb_top: %0d built chains freed, longest %0d pages, %0d mismatches",
               chains_freed, longest_chain, err_count);
      if (err_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

// File: filelist.f
src/pcat_pkg.sv
src/pcat_ram.sv
src/pcat_ctrl.sv
src/page_chain_allocation_table_unit.sv
tb/pcat_checker.sv
tb/tb_top.sv
